// ----- design/mecanum_pose_integrator_assert.svh -----
// Assertion helpers for the checker file of the pose integrator.
`ifndef MECANUM_POSE_INTEGRATOR_ASSERT_SVH
`define MECANUM_POSE_INTEGRATOR_ASSERT_SVH

// Same-cycle implication, sampled on the rising edge of clk.
`define MPI_ASSERT_IMP(lbl, clk, dis, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising edge of clk.
`define MPI_ASSERT_NXT(lbl, clk, dis, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/mpi_pkg.sv -----
`timescale 1ns / 1ps

package mpi_pkg;

  localparam int WORD_W      = 32;
  localparam int ANGLE_W     = 32;
  // Sums of four 32-bit words need two guard bits.
  localparam int SUM_W       = 34;
  localparam int MUL_A_W     = SUM_W;
  localparam int MUL_B_W     = 32;
  localparam int HALF_W      = MUL_B_W / 2;
  localparam int PROD_W      = MUL_A_W + MUL_B_W;
  localparam int GAIN_FRAC_W = 16;
  localparam int CW          = 34;
  localparam int ZW          = 34;
  localparam int ATAN_IDX_W  = 5;
  localparam int CFG_IDX_W   = 2;

  localparam int CORDIC_STEPS_DEF = 24;

  // Inverse CORDIC gain as an unsigned Q0.32 fraction.
  localparam logic [MUL_B_W-1:0] INV_GAIN = 32'h9B74_EDA8;

  localparam logic [CFG_IDX_W-1:0] REG_USE_INERTIAL  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEADING_GAIN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RESET_HEADING = 2'd2;

  typedef struct packed {
    logic signed [WORD_W-1:0] delta_one;
    logic signed [WORD_W-1:0] delta_two;
    logic signed [WORD_W-1:0] delta_three;
    logic signed [WORD_W-1:0] delta_four;
    logic signed [WORD_W-1:0] travel_one;
    logic signed [WORD_W-1:0] travel_two;
    logic signed [WORD_W-1:0] travel_three;
    logic signed [WORD_W-1:0] travel_four;
    logic [ANGLE_W-1:0]       inertial_angle;
    logic                     inertial_busy;
  } item_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] pose_x;
    logic signed [WORD_W-1:0] pose_y;
    logic [ANGLE_W-1:0]       pose_heading;
  } result_t;

  // Arctangent of 2^-i in binary angle units (full turn is 2^32).
  function automatic logic [ANGLE_W-1:0] atan_at(input logic [ATAN_IDX_W-1:0] idx);
    logic [ANGLE_W-1:0] v;
    case (idx)
      5'd0:    v = 32'd536870912;
      5'd1:    v = 32'd316933406;
      5'd2:    v = 32'd167458907;
      5'd3:    v = 32'd85004756;
      5'd4:    v = 32'd42667331;
      5'd5:    v = 32'd21354465;
      5'd6:    v = 32'd10679838;
      5'd7:    v = 32'd5340245;
      5'd8:    v = 32'd2670163;
      5'd9:    v = 32'd1335087;
      5'd10:   v = 32'd667544;
      5'd11:   v = 32'd333772;
      5'd12:   v = 32'd166886;
      5'd13:   v = 32'd83443;
      5'd14:   v = 32'd41722;
      5'd15:   v = 32'd20861;
      5'd16:   v = 32'd10430;
      5'd17:   v = 32'd5215;
      5'd18:   v = 32'd2608;
      5'd19:   v = 32'd1304;
      5'd20:   v = 32'd652;
      5'd21:   v = 32'd326;
      5'd22:   v = 32'd163;
      5'd23:   v = 32'd81;
      5'd24:   v = 32'd41;
      5'd25:   v = 32'd20;
      5'd26:   v = 32'd10;
      5'd27:   v = 32'd5;
      5'd28:   v = 32'd3;
      5'd29:   v = 32'd1;
      5'd30:   v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

// ----- design/mpi_mul.sv -----
`timescale 1ns / 1ps

// Signed by unsigned multiplier that forms its product from two half-width
// partial products on consecutive cycles.
module mpi_mul (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic signed [mpi_pkg::MUL_A_W-1:0]   mul_a,
  input  logic        [mpi_pkg::MUL_B_W-1:0]   mul_b,
  output logic                                 done,
  output logic signed [mpi_pkg::PROD_W-1:0]    prod
);
  import mpi_pkg::*;

  logic                            busy;
  logic                            half;
  logic signed [MUL_A_W-1:0]       a_r;
  logic        [MUL_B_W-1:0]       b_r;
  logic signed [HALF_W:0]          b_part;
  logic signed [MUL_A_W+HALF_W:0]  part;
  logic signed [PROD_W-1:0]        part_ext;

  always_comb begin
    b_part   = $signed({1'b0, half ? b_r[MUL_B_W-1:HALF_W] : b_r[HALF_W-1:0]});
    part     = a_r * b_part;
    part_ext = {{(PROD_W-MUL_A_W-HALF_W-1){part[MUL_A_W+HALF_W]}}, part};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      half <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        half <= 1'b0;
      end else if (busy) begin
        if (!half) begin
          half <= 1'b1;
        end else begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= mul_a;
      b_r <= mul_b;
    end
    if (busy) begin
      if (!half) begin
        prod <= part_ext;
      end else begin
        prod <= prod + (part_ext <<< HALF_W);
      end
    end
  end

endmodule

// ----- design/mpi_cordic.sv -----
`timescale 1ns / 1ps

// Rotation-mode CORDIC: one micro-rotation per cycle through a single
// shift-and-add unit. The input vector must already carry the gain correction.
module mpi_cordic #(
  parameter int STEPS = mpi_pkg::CORDIC_STEPS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic signed [mpi_pkg::CW-1:0] x0,
  input  logic signed [mpi_pkg::CW-1:0] y0,
  input  logic signed [mpi_pkg::ZW-1:0] z0,
  output logic                          done,
  output logic signed [mpi_pkg::CW-1:0] x_out,
  output logic signed [mpi_pkg::CW-1:0] y_out
);
  import mpi_pkg::*;

  localparam int IW = $clog2(STEPS);

  logic                busy;
  logic [IW-1:0]       cnt;
  logic signed [CW-1:0] x, y, xs, ys, x_next, y_next;
  logic signed [ZW-1:0] z, z_next, at_ext;
  logic [ANGLE_W-1:0]   at;
  logic                 ccw;

  always_comb begin
    xs     = x >>> cnt;
    ys     = y >>> cnt;
    at     = atan_at(ATAN_IDX_W'(cnt));
    at_ext = $signed({{(ZW-ANGLE_W){1'b0}}, at});
    // A residual angle of zero or more turns the vector anticlockwise.
    ccw    = !z[ZW-1];
    x_next = ccw ? x - ys : x + ys;
    y_next = ccw ? y + xs : y - xs;
    z_next = ccw ? z - at_ext : z + at_ext;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == IW'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x <= x0;
      y <= y0;
      z <= z0;
    end else if (busy) begin
      x <= x_next;
      y <= y_next;
      z <= z_next;
    end
  end

  assign x_out = x;
  assign y_out = y;

endmodule

// ----- design/mecanum_pose_integrator.sv -----
`timescale 1ns / 1ps

// Mecanum pose integrator. Each item beat carries four wheel travel deltas,
// four cumulative wheel positions and an inertial heading sample; the block
// forms a new heading (inertial sample plus reset heading, or the signed wheel
// position sum times a Q16.16 gain), turns the local offset of the base by
// minus the mean of the old and new headings, and adds it to the wrapping
// Q24.8 pose, giving one result beat per kept item. In inertial mode an item
// that arrives while the sensor is calibrating is taken and dropped without
// a result or any change of pose. The block handles one item at a time: it
// takes no new item until a kept item has been turned into its result. A
// kept item passes in order through the heading step, the mean heading step,
// the two gain-correction products, the CORDIC rotation and the pose update.
// The CORDIC unit performs one micro-rotation per cycle, and the shared
// multiplier is used three times per item (heading gain and the two
// gain-correction products), each time with a start step, two partial
// products and a done step. The result beat sits in the pose registers
// themselves, so a new item may be accepted while the previous result is
// still waiting to be taken; the block only holds back the next result
// until the old one has gone. Configuration registers may be written at
// any time the block is idle.
module mecanum_pose_integrator #(
  parameter int CORDIC_STEPS = mpi_pkg::CORDIC_STEPS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             item_valid,
  output logic                             item_stall,
  input  mpi_pkg::item_t                   item,
  output logic                             result_valid,
  input  logic                             result_stall,
  output mpi_pkg::result_t                 result,
  input  logic                             cfg_write,
  input  logic [mpi_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mpi_pkg::WORD_W-1:0]       cfg_data
);
  import mpi_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_HEAD   = 4'd1;
  localparam logic [3:0] S_HWAIT  = 4'd2;
  localparam logic [3:0] S_MEAN   = 4'd3;
  localparam logic [3:0] S_PSX    = 4'd4;
  localparam logic [3:0] S_PSXW   = 4'd5;
  localparam logic [3:0] S_PSY    = 4'd6;
  localparam logic [3:0] S_PSYW   = 4'd7;
  localparam logic [3:0] S_RSTART = 4'd8;
  localparam logic [3:0] S_ROT    = 4'd9;
  localparam logic [3:0] S_DONE   = 4'd10;

  logic [3:0] state, state_next;

  // Configuration registers.
  logic               use_inertial;
  logic [WORD_W-1:0]  heading_gain;
  logic [ANGLE_W-1:0] reset_heading;

  // Pose state, which also forms the result beat.
  logic signed [WORD_W-1:0] pos_x, pos_y;
  logic [ANGLE_W-1:0]       heading;

  // Working registers for the item in flight.
  item_t                    item_r;
  logic signed [WORD_W-1:0] lx, ly;
  logic [ANGLE_W-1:0]       new_hd;
  logic [ANGLE_W-1:0]       mean;
  logic                     fold;
  logic signed [ZW-1:0]     z0_r;
  logic signed [CW-1:0]     px, py;

  logic item_accept, result_accept, drop, out_free;

  logic signed [SUM_W-1:0] d1e, d2e, d3e, d4e, t1e, t2e, t3e, t4e;
  logic signed [SUM_W-1:0] wheel_sum, lx_sum, ly_sum;
  logic [ANGLE_W-1:0]      diff, ang;
  logic                    fold_now;
  logic signed [WORD_W:0]  vx, vy;

  logic                      mul_start, mul_done;
  logic signed [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0]        mul_b;
  logic signed [PROD_W-1:0]  mul_prod;

  logic                 cor_start, cor_done;
  logic signed [CW-1:0] cor_x, cor_y;

  assign item_stall    = (state != S_IDLE);
  assign item_accept   = item_valid && !item_stall;
  assign result_accept = result_valid && !result_stall;
  // A calibrating inertial sensor makes the item worthless in inertial mode.
  assign drop          = use_inertial && item.inertial_busy;
  // The pose registers may only change once any waiting result has gone.
  assign out_free      = !result_valid || !result_stall;

  always_comb begin
    result.pose_x       = pos_x;
    result.pose_y       = pos_y;
    result.pose_heading = heading;
  end

  // Wheel sums, all exact in the widened word.
  always_comb begin
    d1e = SUM_W'(item_r.delta_one);
    d2e = SUM_W'(item_r.delta_two);
    d3e = SUM_W'(item_r.delta_three);
    d4e = SUM_W'(item_r.delta_four);
    t1e = SUM_W'(item_r.travel_one);
    t2e = SUM_W'(item_r.travel_two);
    t3e = SUM_W'(item_r.travel_three);
    t4e = SUM_W'(item_r.travel_four);
    wheel_sum = t2e - t1e - t3e + t4e;
    lx_sum    = d1e - d2e - d3e + d4e;
    ly_sum    = d1e + d2e + d3e + d4e;
  end

  // Shortest signed difference between headings, halved with floor in S_MEAN.
  assign diff = new_hd - heading;

  // The rotation angle is minus the mean heading. Angles in the second or
  // third quadrant are folded by a half turn, and the vector negated to match.
  always_comb begin
    ang      = -mean;
    fold_now = ang[ANGLE_W-1] ^ ang[ANGLE_W-2];
    vx       = fold_now ? -(($bits(vx))'(lx)) : ($bits(vx))'(lx);
    vy       = fold ? -(($bits(vy))'(ly)) : ($bits(vy))'(ly);
  end

  // The multiplier serves the heading gain first, then the gain correction
  // of each vector component.
  always_comb begin
    mul_start = (state == S_HEAD) || (state == S_PSX) || (state == S_PSY);
    if (state == S_HEAD) begin
      mul_a = wheel_sum;
      mul_b = heading_gain;
    end else if (state == S_PSX) begin
      mul_a = SUM_W'(vx);
      mul_b = INV_GAIN;
    end else begin
      mul_a = SUM_W'(vy);
      mul_b = INV_GAIN;
    end
  end

  assign cor_start = (state == S_RSTART);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (item_accept && !drop) begin
          state_next = S_HEAD;
        end
      end
      S_HEAD:   state_next = S_HWAIT;
      S_HWAIT: begin
        if (mul_done) begin
          state_next = S_MEAN;
        end
      end
      S_MEAN:   state_next = S_PSX;
      S_PSX:    state_next = S_PSXW;
      S_PSXW: begin
        if (mul_done) begin
          state_next = S_PSY;
        end
      end
      S_PSY:    state_next = S_PSYW;
      S_PSYW: begin
        if (mul_done) begin
          state_next = S_RSTART;
        end
      end
      S_RSTART: state_next = S_ROT;
      S_ROT: begin
        if (cor_done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      use_inertial  <= 1'b0;
      heading_gain  <= '0;
      reset_heading <= '0;
      pos_x         <= '0;
      pos_y         <= '0;
      heading       <= '0;
      result_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        unique case (cfg_index)
          REG_USE_INERTIAL:  use_inertial  <= cfg_data[0];
          REG_HEADING_GAIN:  heading_gain  <= cfg_data;
          REG_RESET_HEADING: reset_heading <= cfg_data;
          default: ;
        endcase
      end
      if (state == S_DONE && out_free) begin
        pos_x        <= pos_x + cor_x[WORD_W-1:0];
        pos_y        <= pos_y + cor_y[WORD_W-1:0];
        heading      <= new_hd;
        result_valid <= 1'b1;
      end else if (result_accept) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_accept) begin
      item_r <= item;
    end
    if (state == S_HEAD) begin
      lx <= lx_sum[SUM_W-1:2];
      ly <= ly_sum[SUM_W-1:2];
    end
    if (state == S_HWAIT && mul_done) begin
      new_hd <= use_inertial ? item_r.inertial_angle + reset_heading
                             : mul_prod[GAIN_FRAC_W +: ANGLE_W];
    end
    if (state == S_MEAN) begin
      mean <= heading + {diff[ANGLE_W-1], diff[ANGLE_W-1:1]};
    end
    if (state == S_PSX) begin
      fold <= fold_now;
      z0_r <= ZW'($signed(fold_now ? {~ang[ANGLE_W-1], ang[ANGLE_W-2:0]} : ang));
    end
    if (state == S_PSXW && mul_done) begin
      px <= mul_prod[PROD_W-1 -: CW];
    end
    if (state == S_PSYW && mul_done) begin
      py <= mul_prod[PROD_W-1 -: CW];
    end
  end

  mpi_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .mul_a (mul_a),
    .mul_b (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  mpi_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cor_start),
    .x0    (px),
    .y0    (py),
    .z0    (z0_r),
    .done  (cor_done),
    .x_out (cor_x),
    .y_out (cor_y)
  );

endmodule

// ----- design/mpi_checker.sv -----
`timescale 1ns / 1ps
`include "mecanum_pose_integrator_assert.svh"

// Port-level checks on the pose integrator.
module mpi_checker (
  input logic             clk,
  input logic             rst,
  input logic             item_valid,
  input logic             item_stall,
  input mpi_pkg::item_t   item,
  input logic             result_valid,
  input logic             result_stall,
  input mpi_pkg::result_t result
);

  `MPI_ASSERT_NXT(a_result_hold, clk, rst, result_valid && result_stall, result_valid, "result beat withdrawn while stalled")
  `MPI_ASSERT_NXT(a_result_stable, clk, rst, result_valid && result_stall, $stable(result), "result beat changed while stalled")
  `MPI_ASSERT_NXT(a_reset_clears, clk, 1'b0, rst, !result_valid, "result valid after reset")
  `MPI_ASSERT_NXT(a_kept_item_busy, clk, rst, item_valid && !item_stall && !item.inertial_busy, item_stall, "kept item did not occupy the block")
  `MPI_ASSERT_IMP(a_result_from_work, clk, rst, $rose(result_valid), $past(item_stall), "result appeared without work in progress")

endmodule

bind mecanum_pose_integrator mpi_checker u_mpi_checker (.*);

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

// Self-checking bench for the mecanum pose integrator. Item beats are driven
// on the falling edge, results are sampled on the rising edge, and every
// result beat is compared with the oldest expected pose, worked out by the
// bench's own model of the integrator or typed into the plan.
module tb;
  import mpi_pkg::*;

  // This margin covers any item still in flight when the last expected pose
  // has come out.
  localparam int DRAIN_CYCLES   = 60;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PHASES         = 10;
  localparam int PHASE_ITEMS    = 130;
  localparam int REPORT_LIMIT   = 10;
  localparam int ROT_STEPS      = (CORDIC_STEPS_DEF > 32) ? 32 : CORDIC_STEPS_DEF;

  // Inverse CORDIC gain, unsigned Q0.32.
  localparam longint INV_GAIN_Q32 = 64'h0000_0000_9B74_EDA8;

  localparam logic [31:0] W_MAX  = 32'h7FFF_FFFF;
  localparam logic [31:0] W_MIN  = 32'h8000_0000;
  localparam logic [31:0] ALL1   = 32'hFFFF_FFFF;
  localparam logic [31:0] UNITY  = 32'h0001_0000;
  localparam logic [31:0] QUART  = 32'h4000_0000;
  localparam logic [31:0] HALF   = 32'h8000_0000;

  // Arctangent of 2^-i as a binary angle, for every micro-rotation.
  localparam logic [0:31][31:0] ATAN_BAM = {
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
  };

  // How a row of the directed plan is used: a register write, an item whose
  // pose comes from the model, an item whose pose is typed into the plan, or
  // an item that must be dropped.
  typedef enum logic [1:0] {ROW_CFG, ROW_MODEL, ROW_TYPED, ROW_DROP} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [31:0]           reg_val;
    item_t                 beat;
    result_t               want;
  } plan_row_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 item_valid;
  logic                 item_stall;
  item_t                item;
  logic                 result_valid;
  logic                 result_stall;
  result_t              result;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [WORD_W-1:0]    cfg_data;

  // The bench's copy of the configuration and of the pose state.
  logic        cfg_inertial;
  logic [31:0] cfg_gain;
  logic [31:0] cfg_base_heading;
  logic [31:0] est_x;
  logic [31:0] est_y;
  logic [31:0] est_heading;

  result_t   pending_poses[$];
  plan_row_t plan[$];
  result_t   front_pose;

  int mismatches    = 0;
  int results_seen  = 0;
  int items_sent    = 0;
  int items_dropped = 0;
  int reg_writes    = 0;
  int quiet_cycles  = 0;
  bit calm;
  bit hold_off_req;

  mecanum_pose_integrator i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  // Works out the pose after one item and advances the model state. Returns
  // zero when the item is dropped because the inertial sensor is calibrating.
  function automatic bit advance_pose(input item_t it, output result_t pose);
    logic [31:0] new_heading;
    logic [31:0] diff;
    logic [31:0] mean;
    logic [31:0] rot;
    logic signed [31:0] sdiff;
    logic [63:0] sum_bits;
    logic [63:0] prod;
    longint d1, d2, d3, d4;
    longint sum, x, y, z, xs, ys;
    pose = '0;
    if (cfg_inertial) begin
      if (it.inertial_busy) return 1'b0;
      new_heading = it.inertial_angle + cfg_base_heading;
    end else begin
      d1 = $signed(it.travel_one);
      d2 = $signed(it.travel_two);
      d3 = $signed(it.travel_three);
      d4 = $signed(it.travel_four);
      sum = -d1 + d2 - d3 + d4;
      sum_bits = sum;
      // Only the bits up to 47 are kept, so a product taken mod 2^64 is exact.
      prod = sum_bits * {32'd0, cfg_gain};
      new_heading = prod[47:16];
    end

    // Mean of old and new heading, going the short way round.
    diff  = new_heading - est_heading;
    sdiff = diff;
    mean  = est_heading + 32'(sdiff >>> 1);

    d1 = $signed(it.delta_one);
    d2 = $signed(it.delta_two);
    d3 = $signed(it.delta_three);
    d4 = $signed(it.delta_four);
    x = (d1 - d2 - d3 + d4) >>> 2;
    y = (d1 + d2 + d3 + d4) >>> 2;

    // Fold the second and third quadrants onto the first and fourth.
    rot = 32'd0 - mean;
    if (rot[31:30] == 2'b01 || rot[31:30] == 2'b10) begin
      x   = -x;
      y   = -y;
      rot = rot + HALF;
    end
    z = longint'($signed(rot));
    x = (x * INV_GAIN_Q32) >>> 32;
    y = (y * INV_GAIN_Q32) >>> 32;
    for (int i = 0; i < ROT_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys;
        y = y + xs;
        z = z - longint'(ATAN_BAM[i]);
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + longint'(ATAN_BAM[i]);
      end
    end

    est_x       = est_x + x[31:0];
    est_y       = est_y + y[31:0];
    est_heading = new_heading;
    pose.pose_x       = est_x;
    pose.pose_y       = est_y;
    pose.pose_heading = est_heading;
    return 1'b1;
  endfunction

  function automatic item_t make_beat(input logic [31:0] d1, d2, d3, d4,
                                      input logic [31:0] t1, t2, t3, t4,
                                      input logic [31:0] angle, input logic busy);
    item_t it;
    it.delta_one      = d1;
    it.delta_two      = d2;
    it.delta_three    = d3;
    it.delta_four     = d4;
    it.travel_one     = t1;
    it.travel_two     = t2;
    it.travel_three   = t3;
    it.travel_four    = t4;
    it.inertial_angle = angle;
    it.inertial_busy  = busy;
    return it;
  endfunction

  function automatic result_t make_pose(input logic [31:0] x, y, heading);
    result_t r;
    r.pose_x       = x;
    r.pose_y       = y;
    r.pose_heading = heading;
    return r;
  endfunction

  // Mostly odometry-sized values, with full-range words and both extremes.
  function automatic logic [31:0] rand_word();
    case ($urandom_range(9))
      0:       return W_MAX;
      1:       return W_MIN;
      2, 3:    return $urandom;
      4, 5, 6: return 32'($urandom_range(8191)) - 32'd4096;
      default: return 32'($urandom_range(2097151)) - 32'd1048576;
    endcase
  endfunction

  task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    plan_row_t row;
    row = '0;
    row.kind    = ROW_CFG;
    row.reg_idx = idx;
    row.reg_val = val;
    plan.push_back(row);
  endtask

  task automatic add_item(input row_kind_t kind, input item_t beat, input result_t want);
    plan_row_t row;
    row = '0;
    row.kind = kind;
    row.beat = beat;
    row.want = want;
    plan.push_back(row);
  endtask

  // Register write on the falling edge, after which the task waits with the enable low
  // so that the write enable never gets two assignments in the same time step.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_USE_INERTIAL:  cfg_inertial     = val[0];
      REG_HEADING_GAIN:  cfg_gain         = val;
      REG_RESET_HEADING: cfg_base_heading = val;
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
  endtask

  // Lets the block run dry: every expected pose out, then enough cycles for
  // an item that causes no result to leave the block as well.
  task automatic settle();
    item_valid <= 1'b0;
    while (pending_poses.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Offers one item beat, waits for it to be taken and records what the block
  // should answer. A typed pose, where given, stands in for the model's pose
  // in the queue, but the model state is advanced all the same.
  task automatic drive_beat(input item_t it, input bit typed, input result_t want,
                            output bit kept);
    result_t pose;
    while (!calm && $urandom_range(99) < 32) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item       <= it;
    item_valid <= 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    kept = advance_pose(it, pose);
    if (kept) pending_poses.push_back(typed ? want : pose);
    else items_dropped++;
    items_sent++;
    @(negedge clk);
  endtask

  // Receiver: random stalls, none during the calm phase, and on request one
  // long hold-off during which the block has to fill up and stall its input.
  initial begin
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        result_stall <= 1'b0;
      end else begin
        result_stall <= !calm && ($urandom_range(99) < 32);
      end
    end
  end

  // Result checker: each result beat against the oldest expected pose.
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      results_seen++;
      if (pending_poses.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("Unexpected result beat: x %h y %h heading %h",
                   result.pose_x, result.pose_y, result.pose_heading);
      end else begin
        front_pose = pending_poses.pop_front();
        if (result.pose_x !== front_pose.pose_x || result.pose_y !== front_pose.pose_y ||
            result.pose_heading !== front_pose.pose_heading) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("Pose mismatch: x exp %h got %h, y exp %h got %h, heading exp %h got %h",
                     front_pose.pose_x, result.pose_x, front_pose.pose_y, result.pose_y,
                     front_pose.pose_heading, result.pose_heading);
        end
      end
    end
  end

  // Watchdog: the run is abandoned when no beat and no write has gone through
  // for far longer than the slowest correct run could need.
  always @(posedge clk) begin
    if (!rst) begin
      if ((item_valid && !item_stall) || (result_valid && !result_stall) || cfg_write)
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: nothing accepted for %0d cycles, %0d poses outstanding",
                 quiet_cycles, pending_poses.size());
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    item_t       beat;
    result_t     none;
    bit          kept;
    logic        inertial;
    logic [31:0] gain;
    logic [31:0] base;
    int          kept_count;
    int          offered;

    rst              = 1'b1;
    item_valid       = 1'b0;
    item             = '0;
    cfg_write        = 1'b0;
    cfg_index        = '0;
    cfg_data         = '0;
    calm             = 1'b0;
    hold_off_req     = 1'b0;
    cfg_inertial     = 1'b0;
    cfg_gain         = '0;
    cfg_base_heading = '0;
    est_x            = '0;
    est_y            = '0;
    est_heading      = '0;
    none             = '0;

    // Directed plan. While the wheel deltas stay at zero the pose stays at the
    // origin, so those rows can carry their expected pose directly.
    // Out of reset: wheel mode with zero gain gives a zero heading, and the
    // busy flag is ignored in wheel mode.
    add_item(ROW_TYPED, make_beat(0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0), make_pose(0, 0, 0));
    add_item(ROW_TYPED, make_beat(0, 0, 0, 0, W_MAX, W_MIN, W_MAX, W_MIN, ALL1, 1'b1),
             make_pose(0, 0, 0));
    // Unity gain: the heading is the signed wheel sum itself.
    add_cfg(REG_HEADING_GAIN, UNITY);
    add_item(ROW_TYPED, make_beat(0, 0, 0, 0, 0, 32'd1000, 0, 0, 0, 1'b0),
             make_pose(0, 0, 32'd1000));
    add_item(ROW_TYPED, make_beat(0, 0, 0, 0, 32'd250, 0, 0, 0, 0, 1'b0),
             make_pose(0, 0, 32'hFFFF_FF06));
    // Inertial mode: heading is sample plus reset heading, wrapping; a beat
    // taken while the sensor calibrates is dropped.
    add_cfg(REG_USE_INERTIAL, 32'd1);
    add_cfg(REG_RESET_HEADING, QUART);
    add_item(ROW_TYPED, make_beat(0, 0, 0, 0, 0, 0, 0, 0, QUART, 1'b0),
             make_pose(0, 0, HALF));
    add_item(ROW_DROP, make_beat(32'd2560, 0, 0, 0, 0, 0, 0, 0, 32'd12345, 1'b1), none);
    add_item(ROW_TYPED, make_beat(0, 0, 0, 0, W_MIN, 0, 0, 0, ALL1, 1'b0),
             make_pose(0, 0, 32'h3FFF_FFFF));
    // Motion in every quadrant, and a heading step across the half turn.
    add_cfg(REG_RESET_HEADING, 32'd0);
    add_item(ROW_MODEL, make_beat(32'd2560, -32'd768, 32'd1792, 32'd128, 0, 0, 0, 0,
                                  32'd0, 1'b0), none);
    add_item(ROW_MODEL, make_beat(32'd2560, -32'd768, 32'd1792, 32'd128, 0, 0, 0, 0,
                                  QUART, 1'b0), none);
    add_item(ROW_MODEL, make_beat(-32'd900, 32'd4000, 32'd77, -32'd3000, 0, 0, 0, 0,
                                  HALF, 1'b0), none);
    add_item(ROW_MODEL, make_beat(32'd2560, -32'd768, 32'd1792, 32'd128, 0, 0, 0, 0,
                                  32'hC000_0000, 1'b0), none);
    add_item(ROW_MODEL, make_beat(32'd5000, 32'd5000, 32'd5000, 32'd5000, 0, 0, 0, 0,
                                  W_MAX, 1'b0), none);
    add_item(ROW_MODEL, make_beat(32'd5000, -32'd5000, -32'd5000, 32'd5000, 0, 0, 0, 0,
                                  32'h8000_0001, 1'b0), none);
    add_item(ROW_MODEL, make_beat(W_MAX, W_MAX, W_MAX, W_MAX, 0, 0, 0, 0,
                                  32'hBFFF_FFFF, 1'b0), none);
    // Back to wheel mode with the largest gain and the widest wheel sums.
    add_cfg(REG_USE_INERTIAL, 32'd0);
    add_cfg(REG_HEADING_GAIN, ALL1);
    add_item(ROW_MODEL, make_beat(0, 0, 0, 0, W_MIN, W_MAX, W_MIN, W_MAX, 0, 1'b0), none);
    add_item(ROW_MODEL, make_beat(0, 0, 0, 0, W_MAX, W_MIN, W_MAX, W_MIN, 0, 1'b0), none);
    add_item(ROW_MODEL, make_beat(W_MIN, W_MIN, W_MIN, W_MIN, ALL1, 0, 0, 32'd3, 0, 1'b0),
             none);
    add_item(ROW_MODEL, make_beat(W_MAX, W_MIN, W_MIN, W_MAX, 0, 32'd7, 0, 0, 0, 1'b0),
             none);
    add_item(ROW_MODEL, make_beat(W_MIN, W_MAX, W_MAX, W_MIN, W_MIN, W_MIN, 0, 0,
                                  ALL1, 1'b1), none);
    add_item(ROW_MODEL, make_beat(ALL1, ALL1, ALL1, ALL1, ALL1, ALL1, ALL1, ALL1,
                                  ALL1, 1'b1), none);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        settle();
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        drive_beat(plan[i].beat, plan[i].kind == ROW_TYPED, plan[i].want, kept);
      end
    end

    // Random phases, each with its own register setting. The first three pin
    // the extremes: largest gain, largest reset heading in inertial mode, and
    // zero gain. Phase 3 carries the long result hold-off, phase 5 runs with
    // no idling on either side.
    for (int p = 0; p < PHASES; p++) begin
      settle();
      inertial = (p == 1) ? 1'b1 : (p == 0 || p == 2) ? 1'b0 : 1'($urandom_range(1));
      case (p)
        0:       gain = ALL1;
        2:       gain = 32'd0;
        default: begin
          case ($urandom_range(3))
            0:       gain = UNITY;
            1:       gain = $urandom;
            2:       gain = 32'($urandom_range(262143));
            default: gain = ALL1;
          endcase
        end
      endcase
      base = (p == 1) ? ALL1 : (p == 3) ? 32'd0 : $urandom;
      write_reg(REG_USE_INERTIAL, {31'd0, inertial});
      write_reg(REG_HEADING_GAIN, gain);
      write_reg(REG_RESET_HEADING, base);
      calm = (p == 5);
      kept_count = 0;
      offered    = 0;
      while (kept_count < PHASE_ITEMS) begin
        beat = make_beat(rand_word(), rand_word(), rand_word(), rand_word(),
                         rand_word(), rand_word(), rand_word(), rand_word(), $urandom,
                         cfg_inertial ? ($urandom_range(9) == 0) : 1'($urandom_range(1)));
        if (p == 3 && offered == 20) hold_off_req = 1'b1;
        drive_beat(beat, 1'b0, none, kept);
        if (kept) kept_count++;
        offered++;
      end
      calm = 1'b0;
    end

    settle();
    $display("Checked %0d pose results from %0d item beats (%0d dropped while calibrating)",
             results_seen, items_sent, items_dropped);
    $display("over %0d register writes, with a %0d-cycle result hold-off and a stall-free phase",
             reg_writes, HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
